// ===== src/tdip_pkg.sv =====
// Shared types, codes and constants for the typed decimal integer parser.
// Used by every module of the block; depends on nothing.
package tdip_pkg;

  // Character codes the parser looks at
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_L    = 8'h6C;
  localparam logic [7:0] CH_UPPER_L    = 8'h4C;
  localparam logic [7:0] CH_LOWER_U    = 8'h75;
  localparam logic [7:0] CH_UPPER_U    = 8'h55;

  // Width select in kind bits 1:0
  localparam logic [1:0] WIDTH_64 = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_START  = 2'd1,
    PH_SIGNED = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NODIGIT = 3'd1,
    ST_LARGE   = 3'd2,
    ST_SIGN    = 3'd3,
    ST_SUFFIX  = 3'd4
  } status_t;

  // Input request as it arrives on the port
  typedef struct packed {
    logic [7:0] char_code;
    logic       start_req;
    logic [2:0] opcode;
  } in_req_t;

  // Result request as it leaves the block
  typedef struct packed {
    logic [63:0] value;
    status_t     status;
    logic        char_consumed;
  } out_req_t;

  // Classified character, carried from the front to the back
  typedef struct packed {
    logic       start;
    logic [2:0] kind;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_minus;
    logic       is_underscore;
    logic       is_suffix_l;
    logic       is_suffix_u;
  } item_t;

  // Queue status seen by the front and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Largest accumulator that may still take another digit
  function automatic logic [63:0] digit_limit(input logic [2:0] kind);
    logic [63:0] lim;
    begin
      case (kind)
        3'd0:    lim = 64'hB;
        3'd1:    lim = 64'hCCB;
        3'd2:    lim = 64'hCCCCCCB;
        3'd3:    lim = 64'h0CCC_CCCC_CCCC_CCCB;
        3'd4:    lim = 64'h18;
        3'd5:    lim = 64'h1998;
        3'd6:    lim = 64'h19999998;
        3'd7:    lim = 64'h1999_9999_9999_9998;
        default: lim = 64'h0;
      endcase
      return lim;
    end
  endfunction

endpackage

// ===== src/tdip_front.sv =====
// Front of the parser: accepts input requests and classifies each character.
// Depends on tdip_pkg; feeds tdip_queue.
module tdip_front (
  input  logic             in_valid,
  input  tdip_pkg::in_req_t in_data,
  input  tdip_pkg::q_stat_t q_stat,
  output logic             in_stall,
  output logic             push,
  output tdip_pkg::item_t  push_item
);

  logic [7:0] ch;
  logic [7:0] ch_off;

  // Stall while the queue has no room
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Classify the character
  always_comb begin
    ch     = in_data.char_code;
    ch_off = ch - tdip_pkg::CH_ZERO;
    push_item.start         = in_data.start_req;
    push_item.kind          = in_data.opcode;
    push_item.is_digit      = (ch >= tdip_pkg::CH_ZERO) && (ch <= tdip_pkg::CH_NINE);
    push_item.digit         = ch_off[3:0];
    push_item.is_minus      = (ch == tdip_pkg::CH_MINUS);
    push_item.is_underscore = (ch == tdip_pkg::CH_UNDERSCORE);
    push_item.is_suffix_l   = (ch == tdip_pkg::CH_LOWER_L) || (ch == tdip_pkg::CH_UPPER_L);
    push_item.is_suffix_u   = (ch == tdip_pkg::CH_LOWER_U) || (ch == tdip_pkg::CH_UPPER_U);
  end

endmodule

// ===== src/tdip_queue.sv =====
// Two-entry queue of classified characters between front and back.
// Depends on tdip_pkg.
module tdip_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tdip_pkg::item_t   push_item,
  input  logic              pop,
  output tdip_pkg::item_t   pop_item,
  output tdip_pkg::q_stat_t q_stat
);

  tdip_pkg::item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign pop_item     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/tdip_back.sv =====
// Back of the parser: literal state machine, accumulator and result register.
// Depends on tdip_pkg; drains tdip_queue.
module tdip_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  tdip_pkg::item_t    item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output tdip_pkg::out_req_t out_data
);

  tdip_pkg::phase_t   phase_r, phase_nxt, phase_eff;
  logic [63:0]        acc_r, acc_nxt, acc_eff, acc_mul, lim;
  logic               neg_r, neg_nxt, neg_eff;
  logic [2:0]         kind_r, kind_nxt, kind_eff;
  logic               au_r, au_nxt, au_eff;
  logic               out_valid_r, out_valid_nxt;
  tdip_pkg::out_req_t out_data_r, out_data_nxt;
  logic               emit;
  tdip_pkg::out_req_t res;
  logic [63:0]        final_val;
  logic               is_unsigned, is_wide, over, suffix_ok;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Take one character whenever the result slot is free or draining
  assign pop = !q_empty && (!out_valid_r || !out_stall);

  // Next state and result
  always_comb begin
    // A start restarts the literal with this character
    phase_eff = item.start ? tdip_pkg::PH_START : phase_r;
    acc_eff   = item.start ? 64'd0 : acc_r;
    neg_eff   = item.start ? 1'b0 : neg_r;
    kind_eff  = item.start ? item.kind : kind_r;
    au_eff    = item.start ? 1'b0 : au_r;

    is_unsigned = kind_eff[2];
    is_wide     = (kind_eff[1:0] == tdip_pkg::WIDTH_64);
    lim         = tdip_pkg::digit_limit(kind_eff);
    over        = (acc_eff > lim);
    acc_mul     = {acc_eff[60:0], 3'b000} + {acc_eff[62:0], 1'b0} + {60'd0, item.digit};
    final_val   = (!is_unsigned && neg_eff) ? (64'd0 - acc_eff) : acc_eff;
    suffix_ok   = is_unsigned ? item.is_suffix_u : item.is_suffix_l;

    phase_nxt = phase_eff;
    acc_nxt   = acc_eff;
    neg_nxt   = neg_eff;
    kind_nxt  = kind_eff;
    au_nxt    = au_eff;
    emit      = 1'b0;
    res.value         = 64'd0;
    res.status        = tdip_pkg::ST_OK;
    res.char_consumed = 1'b0;

    case (phase_eff)
      tdip_pkg::PH_START, tdip_pkg::PH_SIGNED: begin
        if (phase_eff == tdip_pkg::PH_START && item.is_minus) begin
          if (is_unsigned) begin
            emit       = 1'b1;
            res.status = tdip_pkg::ST_SIGN;
          end else begin
            neg_nxt   = 1'b1;
            phase_nxt = tdip_pkg::PH_SIGNED;
          end
        end else if (!item.is_digit) begin
          emit       = 1'b1;
          res.status = tdip_pkg::ST_NODIGIT;
        end else if (over) begin
          emit       = 1'b1;
          res.status = tdip_pkg::ST_LARGE;
        end else begin
          acc_nxt   = acc_mul;
          au_nxt    = 1'b0;
          phase_nxt = tdip_pkg::PH_DIGITS;
        end
      end
      tdip_pkg::PH_DIGITS: begin
        if (item.is_digit) begin
          if (over) begin
            emit       = 1'b1;
            res.status = tdip_pkg::ST_LARGE;
          end else begin
            acc_nxt = acc_mul;
            au_nxt  = 1'b0;
          end
        end else if (is_wide) begin
          if (item.is_underscore && !au_eff) begin
            au_nxt = 1'b1;
          end else if (suffix_ok) begin
            emit              = 1'b1;
            res.value         = final_val;
            res.char_consumed = 1'b1;
          end else begin
            emit       = 1'b1;
            res.status = tdip_pkg::ST_SUFFIX;
          end
        end else begin
          emit      = 1'b1;
          res.value = final_val;
        end
      end
      default: begin
        // Idle without a start: drop the character
      end
    endcase

    // A result ends the literal
    if (emit) begin
      phase_nxt = tdip_pkg::PH_IDLE;
      au_nxt    = 1'b0;
    end

    // Hold the result until taken
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (pop && emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tdip_pkg::PH_IDLE;
      acc_r       <= 64'd0;
      neg_r       <= 1'b0;
      kind_r      <= 3'd0;
      au_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        kind_r  <= kind_nxt;
        au_r    <= au_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== src/typed_decimal_integer_parser_top.sv =====
// Top level of the typed decimal integer parser.
// Depends on tdip_pkg, tdip_front, tdip_queue and tdip_back.
//
// The parser takes one character per cycle while in_stall is low and, at the
// end of each literal, gives one result request (value, status, whether the
// ending character was consumed). Sustained throughput is one character per
// clock while neither side stalls: the back end updates the accumulator
// (times ten plus digit, limit compare) combinationally. A character reaches
// the back end through a two-entry queue, and a result passes the queue entry
// and then the result register. While the result register is stalled the
// queue absorbs two more characters before in_stall rises.
module typed_decimal_integer_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tdip_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tdip_pkg::out_req_t out_data
);

  logic              push;
  logic              pop;
  tdip_pkg::item_t   push_item;
  tdip_pkg::item_t   pop_item;
  tdip_pkg::q_stat_t q_stat;

  tdip_front u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .in_stall  (in_stall),
    .push      (push),
    .push_item (push_item)
  );

  tdip_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  tdip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_stat.empty),
    .item      (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A request accepted into an empty queue is visible next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && q_stat.empty) |=> !q_stat.empty)
    else $error("queue lost an accepted request");

  // Only a successful wide literal consumes its ending character
  a_consume_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.char_consumed) |-> (out_data.status == tdip_pkg::ST_OK))
    else $error("consumed character on a failed literal");

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != tdip_pkg::ST_OK) |-> (out_data.value == 64'd0))
    else $error("error result with nonzero value");

  // Back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

// ===== sim/tdip_literal_checker.sv =====
// Result checker for the typed decimal integer parser.
// Watches both request channels, predicts each literal's result and compares in order.
// Depends on tdip_pkg for the request types, status codes and character codes.
module tdip_literal_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  tdip_pkg::in_req_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  tdip_pkg::out_req_t out_data,
  output int                 mismatches,
  output int                 results_checked,
  output int                 pending
);

  // Largest accumulator that may still take a digit, by width select
  localparam logic [63:0] SIGNED_CEIL [4] = '{
    64'hB, 64'hCCB, 64'hCCC_CCCB, 64'h0CCC_CCCC_CCCC_CCCB
  };
  localparam logic [63:0] UNSIGNED_CEIL [4] = '{
    64'h18, 64'h1998, 64'h1999_9998, 64'h1999_9999_9999_9998
  };

  // Predicted parser state
  logic [63:0]      total;
  logic             minus_seen;
  logic [2:0]       lit_kind;
  tdip_pkg::phase_t lit_phase;
  logic             us_skipped;

  tdip_pkg::out_req_t pending_literals[$];

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Advance the predicted state by one character; return 1 when a literal ends
  function automatic bit parse_step(input tdip_pkg::in_req_t req,
                                    output tdip_pkg::out_req_t res);
    logic [7:0]  ch;
    logic [63:0] ceil;
    bit          is_num;
    bit          uns;
    bit          wide;
    bit          suffix;
    bit          ends;
    ch = req.char_code;
    is_num = (ch >= tdip_pkg::CH_ZERO) && (ch <= tdip_pkg::CH_NINE);
    res = '{value: 64'd0, status: tdip_pkg::ST_OK, char_consumed: 1'b0};
    ends = 1'b0;
    // a start drops any literal in progress
    if (req.start_req) begin
      total = 64'd0;
      minus_seen = 1'b0;
      us_skipped = 1'b0;
      lit_kind = req.opcode;
      lit_phase = tdip_pkg::PH_START;
    end
    uns = lit_kind[2];
    wide = (lit_kind[1:0] == tdip_pkg::WIDTH_64);
    ceil = uns ? UNSIGNED_CEIL[lit_kind[1:0]] : SIGNED_CEIL[lit_kind[1:0]];
    suffix = uns ? (ch == tdip_pkg::CH_LOWER_U || ch == tdip_pkg::CH_UPPER_U)
                 : (ch == tdip_pkg::CH_LOWER_L || ch == tdip_pkg::CH_UPPER_L);
    if (lit_phase == tdip_pkg::PH_START && ch == tdip_pkg::CH_MINUS) begin
      if (uns) begin
        ends = 1'b1;
        res.status = tdip_pkg::ST_SIGN;
      end else begin
        minus_seen = 1'b1;
        lit_phase = tdip_pkg::PH_SIGNED;
      end
    end else if (lit_phase == tdip_pkg::PH_START || lit_phase == tdip_pkg::PH_SIGNED ||
                 (lit_phase == tdip_pkg::PH_DIGITS && is_num)) begin
      // take a digit unless the accumulator is already past the ceiling
      if (!is_num) begin
        ends = 1'b1;
        res.status = tdip_pkg::ST_NODIGIT;
      end else if (total > ceil) begin
        ends = 1'b1;
        res.status = tdip_pkg::ST_LARGE;
      end else begin
        total = total * 64'd10 + {56'd0, ch - tdip_pkg::CH_ZERO};
        us_skipped = 1'b0;
        lit_phase = tdip_pkg::PH_DIGITS;
      end
    end else if (lit_phase == tdip_pkg::PH_DIGITS) begin
      // skip one underscore on 64-bit kinds, otherwise close the literal
      if (wide && ch == tdip_pkg::CH_UNDERSCORE && !us_skipped) begin
        us_skipped = 1'b1;
      end else begin
        ends = 1'b1;
        if (wide && !suffix) begin
          res.status = tdip_pkg::ST_SUFFIX;
        end else begin
          res.value = (!uns && minus_seen) ? 64'd0 - total : total;
          res.char_consumed = wide;
        end
      end
    end
    if (ends) begin
      lit_phase = tdip_pkg::PH_IDLE;
      us_skipped = 1'b0;
    end
    return ends;
  endfunction

  always @(posedge clk) begin
    tdip_pkg::out_req_t want;
    tdip_pkg::out_req_t made;
    if (!rst_n) begin
      total = 64'd0;
      minus_seen = 1'b0;
      lit_kind = 3'd0;
      lit_phase = tdip_pkg::PH_IDLE;
      us_skipped = 1'b0;
      pending_literals.delete();
      mismatches = 0;
      results_checked = 0;
      pending <= 0;
    end else begin
      // compare each accepted result with the oldest expectation
      if (out_valid && !out_stall) begin
        results_checked++;
        if (pending_literals.size() == 0) begin
          report_mismatch($sformatf("result with none expected: value=%h status=%0d used=%0b",
                                    out_data.value, out_data.status, out_data.char_consumed));
        end else begin
          want = pending_literals.pop_front();
          if (out_data.value !== want.value || out_data.status !== want.status ||
              out_data.char_consumed !== want.char_consumed)
            report_mismatch($sformatf(
              "result %0d: got value=%h status=%0d used=%0b, want value=%h status=%0d used=%0b",
              results_checked, out_data.value, out_data.status, out_data.char_consumed,
              want.value, want.status, want.char_consumed));
        end
      end
      // predict on each accepted character
      if (in_valid && !in_stall) begin
        if (parse_step(in_data, made)) pending_literals.push_back(made);
      end
      pending <= pending_literals.size();
    end
  end

endmodule

// ===== sim/tb_typed_decimal_integer_parser_top.sv =====
// Testbench top for the typed decimal integer parser.
// Drives character requests and result stalls; tdip_literal_checker does the checking.
// Depends on tdip_pkg, typed_decimal_integer_parser_top and tdip_literal_checker.
module tb_typed_decimal_integer_parser_top;

  // Literal kinds: bits 1:0 select the width, bit 2 marks unsigned
  localparam logic [2:0] KIND_S8  = 3'd0;
  localparam logic [2:0] KIND_S16 = 3'd1;
  localparam logic [2:0] KIND_S32 = 3'd2;
  localparam logic [2:0] KIND_S64 = 3'd3;
  localparam logic [2:0] KIND_U8  = 3'd4;
  localparam logic [2:0] KIND_U16 = 3'd5;
  localparam logic [2:0] KIND_U32 = 3'd6;
  localparam logic [2:0] KIND_U64 = 3'd7;

  localparam int RANDOM_CHARS  = 1700;
  localparam int DIRECTED_CHARS = 26;
  localparam int HOLD_CYCLES   = 48;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  tdip_pkg::in_req_t  in_data;
  logic               out_valid;
  logic               out_stall;
  tdip_pkg::out_req_t out_data;

  int mismatches;
  int results_checked;
  int pending;

  int  chars_sent;
  int  literals_sent;
  bit  quiet;
  bit  long_hold_req;

  logic [7:0] lit_text[$];
  string      term_chars = " ,;)_LUlu+.";

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typed_decimal_integer_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  tdip_literal_checker u_literal_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .results_checked (results_checked),
    .pending         (pending)
  );

  // Offer one character request and hold it until accepted, then maybe idle
  task automatic send_char(logic [7:0] ch, bit first, logic [2:0] op, bit live);
    in_valid <= 1'b1;
    in_data <= '{char_code: ch, start_req: first, opcode: op};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (live) chars_sent++;
    if (!quiet && !long_hold_req && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Send the buffered literal; only its first character carries the kind
  task automatic send_lit(logic [2:0] op);
    literals_sent++;
    for (int i = 0; i < lit_text.size(); i++)
      send_char(lit_text[i], i == 0, (i == 0) ? op : 3'($urandom_range(0, 7)), 1'b1);
  endtask

  task automatic send_word(string s, logic [2:0] op);
    lit_text.delete();
    for (int i = 0; i < s.len(); i++) lit_text.push_back(s[i]);
    send_lit(op);
  endtask

  // Append a digit; on 64-bit kinds sometimes follow it with underscores
  function automatic void add_digit(logic [7:0] d, bit wide);
    int r;
    lit_text.push_back(d);
    r = $urandom_range(0, 99);
    if (wide && r < 8) begin
      lit_text.push_back(tdip_pkg::CH_UNDERSCORE);
    end else if (wide && r < 9) begin
      lit_text.push_back(tdip_pkg::CH_UNDERSCORE);
      lit_text.push_back(tdip_pkg::CH_UNDERSCORE);
    end
  endfunction

  // Build and send one literal: mostly well formed, some broken
  task automatic send_random_literal();
    logic [2:0]  op;
    logic [63:0] ceil;
    string       num;
    bit          uns;
    bit          wide;
    int          style;
    int          span;
    int          r;
    op = 3'($urandom_range(0, 7));
    uns = op[2];
    wide = (op[1:0] == tdip_pkg::WIDTH_64);
    style = $urandom_range(0, 99);
    lit_text.delete();
    if (style < 4) begin
      // open with any byte at all
      lit_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 99) < (uns ? 4 : 35)) lit_text.push_back(tdip_pkg::CH_MINUS);
      // a minus ends an unsigned literal, so stop there
      if (!(uns && lit_text.size() != 0)) begin
        if (style >= 35) begin
          span = (op[1:0] == 2'd0) ? 3 : (op[1:0] == 2'd1) ? 5 : (op[1:0] == 2'd2) ? 10 : 20;
          repeat ($urandom_range(1, span))
            add_digit(tdip_pkg::CH_ZERO + 8'($urandom_range(0, 9)), wide);
        end else if (style >= 10) begin
          // walk right up to, or just past, the digit ceiling
          ceil = tdip_pkg::digit_limit(op) + 64'($urandom_range(0, 1));
          num = $sformatf("%0d", ceil);
          for (int i = 0; i < num.len(); i++) add_digit(num[i], wide);
          repeat ($urandom_range(0, 2))
            add_digit(tdip_pkg::CH_ZERO + 8'($urandom_range(0, 9)), wide);
        end
        // close with a suffix, a stray character, or let the next start cut in
        r = $urandom_range(0, 99);
        if (r >= 5) begin
          if (wide && r < 75)
            lit_text.push_back(uns ? (r[0] ? tdip_pkg::CH_LOWER_U : tdip_pkg::CH_UPPER_U)
                                   : (r[0] ? tdip_pkg::CH_LOWER_L : tdip_pkg::CH_UPPER_L));
          else if (r < 92)
            lit_text.push_back(term_chars[$urandom_range(0, term_chars.len() - 1)]);
          else
            lit_text.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
    send_lit(op);
  endtask

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    bit drained;
    int waited;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed literals: each kind, each status, underscores, restart mid-literal
    send_char(8'h41, 1'b0, KIND_U64, 1'b0);
    send_word("0 ", KIND_U8);
    send_word("-", KIND_U8);
    send_char(8'hFF, 1'b1, KIND_S8, 1'b1);
    send_word("-;", KIND_S16);
    send_word("259", KIND_U8);
    send_word("-2_", KIND_S32);
    send_word("9_9u", KIND_U64);
    send_word("1__", KIND_S64);
    send_word("5x", KIND_S64);
    send_word("8L", KIND_S64);
    send_word("4", KIND_U32);
    send_word("3,", KIND_U16);

    // random literals with occasional ignored noise
    while (chars_sent < DIRECTED_CHARS + RANDOM_CHARS) begin
      if (literals_sent == 30) long_hold_req = 1'b1;
      if (literals_sent == 70) begin
        // hold off until the parser has handed back every result
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (chars_sent > DIRECTED_CHARS + RANDOM_CHARS - 250) quiet = 1'b1;
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 3))
          send_char(8'($urandom_range(0, 255)), 1'b0, 3'($urandom_range(0, 7)), 1'b0);
      send_random_literal();
    end

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    drained = (pending == 0);
    repeat (10) @(posedge clk);

    $display("Run covered %0d characters in %0d literals of all eight kinds,",
             chars_sent, literals_sent);
    $display("with stalls on both sides; compared %0d results: %0d mismatches, %0d still owed.",
             results_checked, mismatches, pending);
    if (drained && mismatches == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
